// ----- src/spims_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shift engine package
// Shared item types, command codes and register indexes.
// ----------------------------------------------------------------------------
package spims_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned BITCNT_W    = 5;
    localparam int unsigned TICK_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [BITCNT_W-1:0] WORD_BITS_SHORT = 5'd8;
    localparam logic [BITCNT_W-1:0] WORD_BITS_LONG  = 5'd16;
    localparam logic [WORD_W-1:0]   WORD_MASK_SHORT = 16'h00FF;
    localparam logic [WORD_W-1:0]   WORD_MASK_LONG  = 16'hFFFF;

    // Phase in which MISO is captured on entry.
    localparam logic [1:0] PHASE_SAMPLE = 2'd3;
    localparam logic [1:0] PHASE_LOW    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORD_SIXTEEN = 2'd0,
        CFG_MSB_FIRST    = 2'd1,
        CFG_PHASE_TICKS  = 2'd2
    } t_cfg_index;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] tx_word;
        logic              miso_level;
    } t_in_item;

    typedef struct packed {
        logic              sclk_level;
        logic              mosi_level;
        logic              busy_res;
        logic              done_res;
        logic [WORD_W-1:0] rx_word;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_item;

    typedef struct packed {
        logic              word_sixteen;
        logic              msb_first;
        logic [TICK_W-1:0] phase_ticks;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [WORD_W-1:0] tx_word;
        logic              miso_level;
    } t_cmd;

endpackage

// ----- src/spims_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload item per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface spims_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/spi_master_shift_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shift engine
// Idle-high SPI clock shifter driven by start and tick items.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  i_in     sink       action, tx_word, miso_level
//  o_out    source     sclk_level, mosi_level, busy_res, done_res, rx_word
//  i_cfg    sink       reg_index, wr_data (word_sixteen, msb_first, phase_ticks)
//
//  One item per clock is sustained while results are taken; each item yields one result.
//  An accepted item is registered in the command queue and then in the result
//  register before its result is valid.
//  Synchronous active-low reset returns to idle with default register values.
//  A stalled result holds the engine; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module spi_master_shift_engine_unit
    import spims_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spims_chan_if.sink    i_in,
    spims_chan_if.source  o_out,
    spims_chan_if.sink    i_cfg
);

    t_cfg      r_cfg;
    t_cmd      w_front_cmd;
    logic      w_front_valid;
    logic      w_q_ready;
    t_cmd      w_q_cmd;
    logic      w_q_valid;
    logic      w_back_ready;
    t_in_item  w_in_data;
    t_cfg_item w_cfg_data;
    t_out_item w_out_data;
    logic      w_out_valid;

    assign w_in_data   = i_in.data;
    assign w_cfg_data  = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_sixteen <= 1'b0;
            r_cfg.msb_first    <= 1'b1;
            r_cfg.phase_ticks  <= TICK_W'(1);
        end else if (i_cfg.valid) begin
            case (w_cfg_data.reg_index)
                CFG_WORD_SIXTEEN: r_cfg.word_sixteen <= w_cfg_data.wr_data[0];
                CFG_MSB_FIRST:    r_cfg.msb_first    <= w_cfg_data.wr_data[0];
                CFG_PHASE_TICKS:  r_cfg.phase_ticks  <= w_cfg_data.wr_data;
                default: begin
                end
            endcase
        end
    end

    spims_front u_front (
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_data   (w_in_data),
        .i_cfg       (r_cfg),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_q_ready),
        .o_cmd       (w_front_cmd)
    );

    spims_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_q_ready),
        .i_push_data  (w_front_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_data   (w_q_cmd)
    );

    spims_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_back_ready),
        .i_cmd       (w_q_cmd),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (w_out_data)
    );

    // A completing result always shows the bus back at idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid && w_out_data.done_res
            |-> !w_out_data.busy_res && w_out_data.sclk_level)
        else $error("done result not idle");

    // After an input item is accepted, the queue holds a valid entry in the next cycle.
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_q_valid)
        else $error("accepted item missing from queue");

    // With work queued, a taken result is replaced in the next cycle.
    a_back_keeps_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && w_out_valid && o_out.ready |=> w_out_valid)
        else $error("engine stalled with work queued");

endmodule

// ----- src/spims_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master front end
// Accepts input items, decodes the action and trims the transmit word.
// ----------------------------------------------------------------------------
module spims_front
    import spims_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  t_cfg     i_cfg,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    assign o_in_ready  = i_cmd_ready;
    assign o_cmd_valid = i_in_valid;

    always_comb begin
        o_cmd.kind       = i_in_data.action ? CMD_TICK : CMD_START;
        o_cmd.tx_word    = i_in_data.tx_word
                         & (i_cfg.word_sixteen ? WORD_MASK_LONG : WORD_MASK_SHORT);
        o_cmd.miso_level = i_in_data.miso_level;
    end

endmodule

// ----- src/spims_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master command queue
// Small FIFO that decouples the front end from the shift engine.
// ----------------------------------------------------------------------------
module spims_queue
    import spims_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

// ----- src/spims_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shift engine core
// Runs the phase timer and shift registers and registers one result per item.
// ----------------------------------------------------------------------------
module spims_back
    import spims_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [WORD_W-1:0]   r_tx, n_tx;
    logic [WORD_W-1:0]   r_rx, n_rx;
    logic [BITCNT_W-1:0] r_bit, n_bit;
    logic [1:0]          r_phase, n_phase;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic                r_active, n_active;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_pop;
    logic [BITCNT_W-1:0] w_nbits;
    logic [WORD_W-1:0]   w_mask;
    logic [TICK_W:0]     w_plen;
    logic [TICK_W:0]     w_tick_inc;
    logic [BITCNT_W-1:0] w_bit_inc;
    logic [BITCNT_W-1:0] w_idx;
    logic [BITCNT_W-1:0] w_top;
    logic                w_done;
    t_out_item           w_item;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_nbits    = i_cfg.word_sixteen ? WORD_BITS_LONG : WORD_BITS_SHORT;
    assign w_mask     = i_cfg.word_sixteen ? WORD_MASK_LONG : WORD_MASK_SHORT;
    assign w_top      = w_nbits - BITCNT_W'(1);
    assign w_plen     = (i_cfg.phase_ticks == '0) ? (TICK_W+1)'(1)
                                                  : {1'b0, i_cfg.phase_ticks};
    assign w_tick_inc = {1'b0, r_tick} + (TICK_W+1)'(1);
    assign w_bit_inc  = r_bit + BITCNT_W'(1);

    always_comb begin
        n_tx     = r_tx;
        n_rx     = r_rx;
        n_bit    = r_bit;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_active = r_active;
        w_done   = 1'b0;

        if (w_pop) begin
            if (i_cmd.kind == CMD_START) begin
                // A start during a transfer is dropped.
                if (!r_active) begin
                    n_tx     = i_cmd.tx_word;
                    n_rx     = '0;
                    n_bit    = '0;
                    n_phase  = '0;
                    n_tick   = '0;
                    n_active = 1'b1;
                end
            end else if (r_active) begin
                if (w_tick_inc < w_plen) begin
                    n_tick = w_tick_inc[TICK_W-1:0];
                end else begin
                    n_tick = '0;
                    if (r_phase != PHASE_SAMPLE) begin
                        n_phase = r_phase + 2'd1;
                        if (r_phase == PHASE_LOW) begin
                            if (i_cfg.msb_first) begin
                                n_rx = {r_rx[WORD_W-2:0], i_cmd.miso_level};
                            end else begin
                                n_rx = (r_rx >> 1)
                                     | (WORD_W'(i_cmd.miso_level) << w_top[3:0]);
                            end
                        end
                    end else begin
                        n_phase = '0;
                        n_bit   = w_bit_inc;
                        if (w_bit_inc >= w_nbits) begin
                            n_active = 1'b0;
                            n_bit    = '0;
                            w_done   = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Output levels follow the state after this item has been applied.
    always_comb begin
        w_idx = i_cfg.msb_first ? (w_top - n_bit) : n_bit;
        if (n_active) begin
            w_item.sclk_level = (n_phase < PHASE_LOW);
            w_item.mosi_level = (n_bit >= w_nbits) ? 1'b0 : n_tx[w_idx[3:0]];
            w_item.busy_res   = 1'b1;
        end else begin
            w_item.sclk_level = 1'b1;
            w_item.mosi_level = 1'b0;
            w_item.busy_res   = 1'b0;
        end
        w_item.done_res = w_done;
        w_item.rx_word  = w_done ? (r_rx & w_mask) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx        <= '0;
            r_rx        <= '0;
            r_bit       <= '0;
            r_phase     <= '0;
            r_tick      <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx     <= n_tx;
            r_rx     <= n_rx;
            r_bit    <= n_bit;
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_active <= n_active;
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= w_item;
        end
    end

endmodule
